@@ src/etdl_pkg.sv @@
package etdl_pkg;

  // field widths fixed by the interface
  localparam int unsigned MaskW    = 64;
  localparam int unsigned AddrW    = 64;
  localparam int unsigned StrideW  = 21;
  localparam int unsigned ActiveW  = 7;
  localparam int unsigned ExpNumW  = 6;
  localparam int unsigned SlotW    = 10;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 64;

  // parameter defaults
  localparam int unsigned MaxTokensDef  = 1024;
  localparam int unsigned MaxExpertsDef = 64;

  // depth of the command queue between front and back
  localparam int unsigned QueueDepth = 2;

  // register reset values
  localparam logic [ActiveW-1:0] ActiveExpertsRst = ActiveW'(16);
  localparam logic [AddrW-1:0]   TokenBaseRst     = '0;
  localparam logic [StrideW-1:0] TokenStrideRst   = StrideW'(8192);

  // configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CfgActiveExperts = 2'd0,
    CfgTokenBase     = 2'd1,
    CfgTokenStride   = 2'd2
  } cfg_idx_e;

  // input item
  typedef struct packed {
    logic [MaskW-1:0] token_mask;
    logic             first_of_batch;
  } in_item_t;

  // result item
  typedef struct packed {
    logic [ExpNumW-1:0] expert_number;
    logic [SlotW-1:0]   list_slot;
    logic [AddrW-1:0]   token_address;
    logic               last_of_token;
    logic               overflow;
  } out_item_t;

  // classified token handed from front to back
  typedef struct packed {
    logic [MaskW-1:0] mask;
    logic [AddrW-1:0] addr;
    logic             ovf;
    logic             clear;
  } cmd_t;

endpackage

@@ src/etdl_front.sv @@
module etdl_front
  import etdl_pkg::*;
#(
  parameter int unsigned MAX_TOKENS  = MaxTokensDef,
  parameter int unsigned MAX_EXPERTS = MaxExpertsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  in_item_t           in_data_i,
  input  logic [ActiveW-1:0] active_experts_i,
  input  logic [AddrW-1:0]   token_base_i,
  input  logic [StrideW-1:0] token_stride_i,
  output logic               push_valid_o,
  input  logic               push_ready_i,
  output cmd_t               push_data_o
);

  localparam int unsigned CntW  = $clog2(MAX_TOKENS + 1);
  localparam int unsigned ProdW = CntW + StrideW;

  logic             accept;
  logic             push;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [CntW-1:0]  cnt_eff;
  logic             ovf;
  logic [MaskW-1:0] keep;
  logic             s1_valid_q;
  logic             s1_clear_q;
  logic             s1_ovf_q;
  logic [MaskW-1:0] s1_mask_q;
  logic [ProdW-1:0] s1_prod_q;

  // handshake
  assign push         = s1_valid_q && push_ready_i;
  assign in_stall_o   = s1_valid_q && !push_ready_i;
  assign accept       = in_valid_i && !in_stall_o;
  assign push_valid_o = s1_valid_q;

  // token index and batch full check
  always_comb begin
    cnt_eff = in_data_i.first_of_batch ? '0 : cnt_q;
    ovf     = cnt_eff >= CntW'(MAX_TOKENS);
    cnt_d   = cnt_q;
    if (accept) begin
      cnt_d = ovf ? cnt_eff : cnt_eff + CntW'(1);
    end
  end

  // experts that are active
  always_comb begin
    for (int e = 0; e < MaskW; e++) begin
      keep[e] = (e < MAX_EXPERTS) && (ActiveW'(e) < active_experts_i);
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q      <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (accept) begin
        s1_valid_q <= 1'b1;
      end else if (push) begin
        s1_valid_q <= 1'b0;
      end
    end
  end

  // stage payload, index times stride
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_clear_q <= in_data_i.first_of_batch;
      s1_ovf_q   <= ovf;
      s1_mask_q  <= in_data_i.token_mask & keep;
      s1_prod_q  <= ProdW'(cnt_eff) * ProdW'(token_stride_i);
    end
  end

  // add base and hand to queue
  always_comb begin
    push_data_o.mask  = s1_mask_q;
    push_data_o.addr  = token_base_i + AddrW'(s1_prod_q);
    push_data_o.ovf   = s1_ovf_q;
    push_data_o.clear = s1_clear_q;
  end

`ifndef SYNTHESIS
  // a dropped token leaves the counter at the batch limit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push && s1_ovf_q |-> cnt_q == CntW'(MAX_TOKENS))
    else $error("dropped token while counter below limit");
`endif

endmodule

@@ src/etdl_fifo.sv @@
module etdl_fifo
  import etdl_pkg::*;
#(
  parameter int unsigned DEPTH = QueueDepth
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_valid_i,
  output logic push_ready_o,
  input  cmd_t push_data_i,
  input  logic pop_i,
  output logic empty_o,
  output cmd_t head_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  cmd_t            mem_q [DEPTH];
  logic [PtrW-1:0] wr_ptr_q;
  logic [PtrW-1:0] rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            push;
  logic            pop;

  assign push_ready_o = count_q != CntW'(DEPTH);
  assign empty_o      = count_q == '0;
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_i && !empty_o;
  assign head_o       = mem_q[rd_ptr_q];

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (push && !pop) begin
        count_q <= count_q + CntW'(1);
      end else if (pop && !push) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

@@ src/etdl_back.sv @@
module etdl_back
  import etdl_pkg::*;
#(
  parameter int unsigned MAX_EXPERTS = MaxExpertsDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      empty_i,
  input  cmd_t      head_i,
  output logic      pop_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_data_o
);

  localparam int unsigned ExpW    = MAX_EXPERTS;
  localparam int unsigned ExpIdxW = $clog2(MAX_EXPERTS);

  function automatic logic [ExpIdxW-1:0] oh_to_idx(input logic [ExpW-1:0] oh);
    logic [ExpIdxW-1:0] idx;
    idx = '0;
    for (int i = 0; i < ExpW; i++) begin
      if (oh[i]) begin
        idx = idx | ExpIdxW'(i);
      end
    end
    return idx;
  endfunction

  // issue stage
  logic               a_valid_q, a_valid_d;
  logic               a_ovf_q;
  logic [ExpW-1:0]    rem_q;
  logic [AddrW-1:0]   a_addr_q;
  logic [ExpW-1:0]    rem_next;
  logic [ExpIdxW-1:0] iss_e;
  logic               a_last;
  logic               a_free;
  logic               load;
  logic               issue;

  // read stage
  logic               b_valid_q;
  logic [ExpIdxW-1:0] b_e_q;
  logic [AddrW-1:0]   b_addr_q;
  logic               b_last_q;
  logic               b_ovf_q;
  logic               b_vbit_q;
  logic               fwd_q;
  logic [SlotW-1:0]   fwd_data_q;
  logic [SlotW-1:0]   rdata_q;
  logic [SlotW-1:0]   b_slot;
  logic               b_adv;
  logic               wr_en;

  // position store and its valid bits
  logic [SlotW-1:0]   pos_mem [MAX_EXPERTS];
  logic [ExpW-1:0]    pv_q;

  // output register
  logic               out_valid_q;
  out_item_t          out_q;

  // pick the lowest routed expert
  always_comb begin
    rem_next = rem_q & (rem_q - ExpW'(1));
    iss_e    = a_ovf_q ? '0 : oh_to_idx(rem_q & (~rem_q + ExpW'(1)));
    a_last   = a_ovf_q || (rem_next == '0);
  end

  // pipeline control
  assign b_adv  = b_valid_q && (!out_valid_q || !out_stall_i);
  assign issue  = a_valid_q && (!b_valid_q || b_adv);
  assign a_free = !a_valid_q || (issue && a_last);
  assign load   = !empty_i && a_free &&
                  (!head_i.clear || (!a_valid_q && !b_valid_q));
  assign pop_o  = load;
  assign wr_en  = b_adv && !b_ovf_q;

  always_comb begin
    a_valid_d = a_valid_q;
    if (load) begin
      a_valid_d = head_i.ovf || (head_i.mask[ExpW-1:0] != '0);
    end else if (issue && a_last) begin
      a_valid_d = 1'b0;
    end
  end

  // current slot, bypassing a write that raced the read
  always_comb begin
    if (fwd_q) begin
      b_slot = fwd_data_q;
    end else begin
      b_slot = b_vbit_q ? rdata_q : '0;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q   <= 1'b0;
      b_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
      fwd_q       <= 1'b0;
      pv_q        <= '0;
    end else begin
      a_valid_q <= a_valid_d;
      if (issue) begin
        b_valid_q <= 1'b1;
      end else if (b_adv) begin
        b_valid_q <= 1'b0;
      end
      if (b_adv) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (issue) begin
        fwd_q <= wr_en && !a_ovf_q && (b_e_q == iss_e);
      end else if (b_adv) begin
        fwd_q <= 1'b0;
      end
      priority if (load && head_i.clear) begin
        pv_q <= '0;
      end else if (wr_en) begin
        pv_q[b_e_q] <= 1'b1;
      end
    end
  end

  // issue stage payload
  always_ff @(posedge clk_i) begin
    if (load) begin
      a_ovf_q  <= head_i.ovf;
      rem_q    <= head_i.mask[ExpW-1:0];
      a_addr_q <= head_i.addr;
    end else if (issue) begin
      rem_q <= rem_next;
    end
  end

  // read stage payload
  always_ff @(posedge clk_i) begin
    if (issue) begin
      b_e_q      <= iss_e;
      b_addr_q   <= a_addr_q;
      b_last_q   <= a_last;
      b_ovf_q    <= a_ovf_q;
      b_vbit_q   <= pv_q[iss_e];
      fwd_data_q <= b_slot + SlotW'(1);
    end
  end

  // position memory, read on issue and written back on transfer to output
  always_ff @(posedge clk_i) begin
    if (issue) begin
      rdata_q <= pos_mem[iss_e];
    end
    if (wr_en) begin
      pos_mem[b_e_q] <= b_slot + SlotW'(1);
    end
  end

  // output payload
  always_ff @(posedge clk_i) begin
    if (b_adv) begin
      if (b_ovf_q) begin
        out_q.expert_number <= '0;
        out_q.list_slot     <= '0;
        out_q.token_address <= '0;
        out_q.last_of_token <= 1'b0;
        out_q.overflow      <= 1'b1;
      end else begin
        out_q.expert_number <= ExpNumW'(b_e_q);
        out_q.list_slot     <= b_slot;
        out_q.token_address <= b_addr_q;
        out_q.last_of_token <= b_last_q;
        out_q.overflow      <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  // a routed token in the issue stage always has an expert left
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    a_valid_q && !a_ovf_q |-> rem_q != '0)
    else $error("issue stage holds a token with no expert left");

  // bypass only refers to an entry waiting in the read stage
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fwd_q |-> b_valid_q)
    else $error("bypass flag without a read stage entry");

  // a written position is valid afterwards
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |=> pv_q[$past(b_e_q)])
    else $error("position write did not mark its entry valid");
`endif

endmodule

@@ src/expert_token_dispatch_lists_unit.sv @@
// Builds per-expert dispatch lists from a stream of token routing masks. Each
// input transfer carries one token's 64-bit mask; for every set bit below the
// active expert count the block emits one result in rising expert order,
// holding the expert number, that expert's next list slot and the token
// address base + index * stride, with last_of_token marking the final entry
// of the token. first_of_batch clears the token counter and all expert
// positions before the token is handled. Once MAX_TOKENS tokens are counted
// in a batch, further tokens are dropped and each returns one result with
// only overflow set. Rate: the back end emits one result per cycle while the
// output is not stalled, one per routed expert (one for a dropped token); a
// token that routes to no active expert yields no result but still takes a
// back-end load. A first_of_batch token waits until the back end's issue and
// read stages have drained. The configuration port writes active_experts
// (index 0), token_base_address (1) and token_stride (2); other indexes are
// ignored.
module expert_token_dispatch_lists_unit
  import etdl_pkg::*;
#(
  parameter int unsigned MAX_TOKENS  = MaxTokensDef,
  parameter int unsigned MAX_EXPERTS = MaxExpertsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  in_item_t            in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output out_item_t           out_data_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  logic [ActiveW-1:0] active_experts_q;
  logic [AddrW-1:0]   token_base_q;
  logic [StrideW-1:0] token_stride_q;

  logic push_valid;
  logic push_ready;
  cmd_t push_data;
  logic pop;
  logic q_empty;
  cmd_t q_head;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_experts_q <= ActiveExpertsRst;
      token_base_q     <= TokenBaseRst;
      token_stride_q   <= TokenStrideRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CfgActiveExperts: active_experts_q <= cfg_data_i[ActiveW-1:0];
        CfgTokenBase:     token_base_q     <= cfg_data_i[AddrW-1:0];
        CfgTokenStride:   token_stride_q   <= cfg_data_i[StrideW-1:0];
        default: ;
      endcase
    end
  end

  // front: counting, drop check, address
  etdl_front #(
    .MAX_TOKENS  (MAX_TOKENS),
    .MAX_EXPERTS (MAX_EXPERTS)
  ) u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .in_data_i        (in_data_i),
    .active_experts_i (active_experts_q),
    .token_base_i     (token_base_q),
    .token_stride_i   (token_stride_q),
    .push_valid_o     (push_valid),
    .push_ready_i     (push_ready),
    .push_data_o      (push_data)
  );

  // command queue
  etdl_fifo #(
    .DEPTH (QueueDepth)
  ) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_i        (pop),
    .empty_o      (q_empty),
    .head_o       (q_head)
  );

  // back: per-expert entries and list positions
  etdl_back #(
    .MAX_EXPERTS (MAX_EXPERTS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (q_empty),
    .head_i      (q_head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule
